@@ src/itp_pkg.sv @@
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CH_SENTINEL = 8'h23;  // '#'
  localparam logic [7:0] CH_LPAREN   = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN   = 8'h29;  // ')'
  localparam logic [7:0] CH_CARET    = 8'h5E;  // '^'
  localparam logic [7:0] CH_DOLLAR   = 8'h24;  // '$'
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_SLASH    = 8'h2F;

  typedef logic signed [4:0] prec_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } symbol_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       is_terminator;
    logic       overflow_seen;
    logic       last;
  } result_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic insert;     // push symbol, or flag overflow when full
    logic pop;        // sp--, start read of new top
    logic fetch;      // load top from read data
    logic emit_top;
    logic emit_term;
    logic finalize;   // hand pending result out with last set
  } itp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic pops;       // sp > 0 and stack prec of top > input prec
    logic match;      // stack prec of top == input prec
    logic sp_zero;
    logic fin;
    logic pend_valid;
    logic out_free;
  } itp_status_t;

  function automatic prec_t prec_in(input logic [7:0] c);
    prec_t p;
    case (c)
      CH_PLUS, CH_MINUS:   p = 5'sd1;
      CH_STAR, CH_SLASH:   p = 5'sd3;
      CH_CARET, CH_DOLLAR: p = 5'sd6;
      CH_LPAREN:           p = 5'sd9;
      CH_RPAREN:           p = 5'sd0;
      default:             p = 5'sd7;
    endcase
    return p;
  endfunction

  function automatic prec_t prec_stack(input logic [7:0] c);
    prec_t p;
    case (c)
      CH_PLUS, CH_MINUS:   p = 5'sd2;
      CH_STAR, CH_SLASH:   p = 5'sd4;
      CH_CARET, CH_DOLLAR: p = 5'sd5;
      CH_LPAREN:           p = 5'sd0;
      CH_SENTINEL:         p = -5'sd1;
      default:             p = 5'sd8;
    endcase
    return p;
  endfunction

endpackage

@@ src/itp_datapath.sv @@
module itp_datapath import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  symbol_item_t item,
  input  logic         result_stall,
  output logic         result_valid,
  output result_item_t result,
  input  itp_cmd_t     cmd,
  output itp_status_t  status
);

  localparam int PTR_W = $clog2(STACK_DEPTH);

  logic [7:0]       mem [STACK_DEPTH];
  logic [7:0]       rdata;
  logic [7:0]       sym;
  logic             fin;
  logic [PTR_W-1:0] sp;
  logic [7:0]       top;
  logic             ovf;
  result_item_t     pend;
  logic             pend_valid;

  logic [PTR_W-1:0] sp_inc;
  logic [PTR_W-1:0] sp_dec;
  logic             full;
  logic             emit;
  result_item_t     new_res;
  result_item_t     pend_last;
  prec_t            p_in;
  prec_t            p_top;

  assign sp_inc = sp + 1'b1;
  assign sp_dec = sp - 1'b1;
  assign full   = (sp == PTR_W'(STACK_DEPTH - 1));
  assign emit   = cmd.emit_top | cmd.emit_term;
  assign p_in   = prec_in(sym);
  assign p_top  = prec_stack(top);

  always_comb begin
    new_res = '0;
    if (cmd.emit_term) begin
      new_res.is_terminator = 1'b1;
      new_res.overflow_seen = ovf;
    end else begin
      new_res.out_char = top;
    end
    pend_last      = pend;
    pend_last.last = 1'b1;
  end

  assign status.pops       = (sp != '0) && (p_top > p_in);
  assign status.match      = (p_top == p_in);
  assign status.sp_zero    = (sp == '0);
  assign status.fin        = fin;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = !result_valid || !result_stall;

  // stack storage; entry zero is never written, the sentinel lives in top
  always_ff @(posedge clk) begin
    if (cmd.insert && !full) begin
      mem[sp_inc] <= sym;
    end
    if (cmd.pop) begin
      rdata <= mem[sp_dec];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sym <= item.symbol;
      fin <= item.end_of_expr;
    end
    if (emit) begin
      pend <= new_res;
    end
    if (emit && pend_valid) begin
      result <= pend;
    end else if (cmd.finalize) begin
      result <= pend_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp           <= '0;
      top          <= CH_SENTINEL;
      ovf          <= 1'b0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.insert) begin
        if (full) begin
          ovf <= 1'b1;
        end else begin
          sp  <= sp_inc;
          top <= sym;
        end
      end
      if (cmd.pop) begin
        sp <= sp_dec;
      end
      if (cmd.fetch) begin
        top <= (sp == '0) ? CH_SENTINEL : rdata;
      end
      if (cmd.emit_term) begin
        sp  <= '0;
        top <= CH_SENTINEL;
        ovf <= 1'b0;
      end

      if (emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.finalize) begin
        pend_valid <= 1'b0;
      end

      if ((emit && pend_valid) || cmd.finalize) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/itp_controller.sv @@
module itp_controller import itp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  itp_status_t status,
  output itp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    EVAL,
    POP_WAIT,
    DISC_WAIT,
    FLUSH,
    FLUSH_WAIT,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   emit_ok;

  assign emit_ok = !status.pend_valid || status.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = EVAL;
        end
      end
      EVAL: begin
        if (status.pops) begin
          if (emit_ok) begin
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
            state_next   = POP_WAIT;
          end
        end else if (status.match && !status.sp_zero) begin
          cmd.pop    = 1'b1;
          state_next = DISC_WAIT;
        end else begin
          cmd.insert = !status.match;
          if (status.fin) begin
            state_next = FLUSH;
          end else if (!status.pend_valid) begin
            state_next = IDLE;
          end else if (status.out_free) begin
            cmd.finalize = 1'b1;
            state_next   = IDLE;
          end else begin
            state_next = FINISH;
          end
        end
      end
      POP_WAIT: begin
        cmd.fetch  = 1'b1;
        state_next = EVAL;
      end
      DISC_WAIT: begin
        cmd.fetch = 1'b1;
        if (status.fin) begin
          state_next = FLUSH;
        end else if (!status.pend_valid) begin
          state_next = IDLE;
        end else if (status.out_free) begin
          cmd.finalize = 1'b1;
          state_next   = IDLE;
        end else begin
          state_next = FINISH;
        end
      end
      FLUSH: begin
        if (emit_ok) begin
          if (!status.sp_zero) begin
            cmd.emit_top = 1'b1;
            cmd.pop      = 1'b1;
            state_next   = FLUSH_WAIT;
          end else begin
            cmd.emit_term = 1'b1;
            state_next    = FINISH;
          end
        end
      end
      FLUSH_WAIT: begin
        cmd.fetch  = 1'b1;
        state_next = FLUSH;
      end
      FINISH: begin
        if (!status.pend_valid) begin
          state_next = IDLE;
        end else if (status.out_free) begin
          cmd.finalize = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      item_stall <= 1'b0;
    end else begin
      state      <= state_next;
      item_stall <= (state_next != IDLE);
    end
  end

endmodule

@@ src/infix_to_postfix_converter_unit.sv @@
// Infix to postfix converter, shunting-yard over a memory-backed operator stack.
// Each operator popped and emitted waits on a stack memory read, a discarded '('
// waits on the refetch of the new top, and the end-of-expression flush pops every entry
// and then emits the terminator and hands it out. Result stalls add wait time. One item
// in flight: no new item is taken until the current one is done. Reset (rst, sync,
// active high): stack back to sentinel, overflow and valids cleared.
module infix_to_postfix_converter_unit import itp_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // input channel: one infix character per transfer
  input  logic         item_valid,
  output logic         item_stall,
  input  symbol_item_t item,
  // result channel: one postfix character or the terminator per transfer
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result
);

  itp_cmd_t    cmd;
  itp_status_t status;

  // Controller sequences pop/push/flush; stall is high for the whole item.
  itp_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // Datapath: stack memory with a registered top, one pending result held
  // back until it is known whether it is the last of its item, and the
  // output register that decouples the result side.
  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .status       (status)
  );

  // a pop and a push never share a cycle
  a_no_pop_push: assert property (@(posedge clk) disable iff (rst)
    !(cmd.pop && cmd.insert))
    else $error("pop and push in the same cycle");

  // an emit that displaces the pending result needs a free output register
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_top || cmd.emit_term) && status.pend_valid |-> status.out_free)
    else $error("emit would overwrite an unaccepted result");

  // the terminator always closes its item
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.is_terminator |-> result.last)
    else $error("terminator without last");

  // once an item is taken, the input stays stalled while it is worked on
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second item taken while busy");

endmodule

@@ tb/sv/infix_to_postfix_checker.sv @@
module infix_to_postfix_checker import itp_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic         item_stall,
  input  symbol_item_t item,
  input  logic         result_valid,
  input  logic         result_stall,
  input  result_item_t result,
  output int           fail_count,
  output int           backlog
);

  // shadow operator stack, entry zero is the sentinel
  logic [7:0]   opstk [DEPTH];
  int           top_idx;
  logic         ovf_sticky;

  result_item_t postfix_q[$];
  result_item_t staged;
  bit           staged_ok;
  result_item_t expected_head;
  int           errs = 0;

  function automatic int input_rank(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS:   return 1;
      CH_STAR, CH_SLASH:   return 3;
      CH_CARET, CH_DOLLAR: return 6;
      CH_LPAREN:           return 9;
      CH_RPAREN:           return 0;
      default:             return 7;
    endcase
  endfunction

  function automatic int stacked_rank(input logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS:   return 2;
      CH_STAR, CH_SLASH:   return 4;
      CH_CARET, CH_DOLLAR: return 5;
      CH_LPAREN:           return 0;
      CH_SENTINEL:         return -1;
      default:             return 8;
    endcase
  endfunction

  // hold back one result so the final one of a symbol can get its last flag
  function void stage_result(input logic [7:0] ch, input logic term, input logic ovf);
    if (staged_ok)
      postfix_q.push_back(staged);
    staged = '{out_char: ch, is_terminator: term, overflow_seen: ovf, last: 1'b0};
    staged_ok = 1'b1;
  endfunction

  function void convert_symbol(input symbol_item_t it);
    int rank;
    rank = input_rank(it.symbol);
    staged_ok = 1'b0;
    while (top_idx > 0 && stacked_rank(opstk[top_idx]) > rank) begin
      stage_result(opstk[top_idx], 1'b0, 1'b0);
      top_idx--;
    end
    if (stacked_rank(opstk[top_idx]) != rank) begin
      if (top_idx >= DEPTH - 1) begin
        ovf_sticky = 1'b1;
      end else begin
        top_idx++;
        opstk[top_idx] = it.symbol;
      end
    end else if (top_idx > 0) begin
      top_idx--;
    end
    if (it.end_of_expr) begin
      // flush goes by count, so a stacked '#' comes out too
      while (top_idx > 0) begin
        stage_result(opstk[top_idx], 1'b0, 1'b0);
        top_idx--;
      end
      stage_result(8'h00, 1'b1, ovf_sticky);
      opstk[0]   = CH_SENTINEL;
      top_idx    = 0;
      ovf_sticky = 1'b0;
    end
    if (staged_ok) begin
      staged.last = 1'b1;
      postfix_q.push_back(staged);
    end
  endfunction

  function void check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++)
        opstk[i] = 8'h00;
      opstk[0]   = CH_SENTINEL;
      top_idx    = 0;
      ovf_sticky = 1'b0;
      postfix_q.delete();
    end else begin
      if (item_valid && !item_stall)
        convert_symbol(item);
      if (result_valid && !result_stall) begin
        if (postfix_q.size() == 0) begin
          $error("unexpected result transfer: out_char %0h", result.out_char);
          errs++;
        end else begin
          expected_head = postfix_q.pop_front();
          check_field("out_char", expected_head.out_char, result.out_char);
          check_field("is_terminator", 8'(expected_head.is_terminator),
                      8'(result.is_terminator));
          check_field("overflow_seen", 8'(expected_head.overflow_seen),
                      8'(result.overflow_seen));
          check_field("last", 8'(expected_head.last), 8'(result.last));
        end
      end
    end
    fail_count <= errs;
    backlog    <= postfix_q.size();
  end

endmodule

@@ tb/sv/tb_infix_to_postfix_converter_unit.sv @@
module tb_infix_to_postfix_converter_unit;
  import itp_pkg::*;

  // quiet cycles (no transfer on either channel) before the run is declared hung
  localparam int WATCHDOG_LIMIT  = 2000;
  // random items per idling phase, three phases
  localparam int ITEMS_PER_PHASE = 56;
  // cycles allowed after the last expected result for any stray transfer
  localparam int SETTLE_CYCLES   = 100;

  // '#', parens, then the six operators at indexes 3..8
  localparam logic [7:0] SPECIALS [9] = '{CH_SENTINEL, CH_LPAREN, CH_RPAREN,
                                          CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                                          CH_CARET, CH_DOLLAR};

  typedef enum {KIND_WELLFORMED, KIND_DEEP, KIND_OVERFLOW, KIND_NOISE} expr_kind_t;

  logic         clk          = 1'b0;
  logic         rst          = 1'b1;
  logic         item_valid   = 1'b0;
  logic         item_stall;
  symbol_item_t item         = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result;

  int           fail_count;
  int           backlog;
  int           send_gap_pct   = 0;
  int           recv_stall_pct = 0;
  int           sent_items     = 0;
  int           quiet_cycles   = 0;
  logic [7:0]   expr_q[$];

  always #5 clk = ~clk;

  infix_to_postfix_converter_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // checker sees both channels, predicts and scores every result transfer
  infix_to_postfix_checker chk (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .backlog      (backlog)
  );

  // receiver back-pressure, fresh coin every cycle, independent of valid
  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: any transfer rearms it; reset time does not count
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send expr_q one symbol per transfer, end_of_expr on the final one.
  // Valid stays up across back-to-back transfers; it only drops for a gap,
  // and the payload holds while stalled.
  task automatic send_expr();
    for (int i = 0; i < expr_q.size(); i++) begin
      if ($urandom_range(0, 99) < send_gap_pct) begin
        item_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
      end
      item_valid <= 1'b1;
      item       <= '{symbol: expr_q[i], end_of_expr: (i == expr_q.size() - 1)};
      do @(posedge clk); while (item_stall);
      sent_items++;
    end
  endtask

  // Hold the sender off until every predicted result has been seen.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (backlog != 0);
  endtask

  function automatic void compose_expr(input expr_kind_t kind);
    int n;
    int open;
    n    = 0;
    open = 0;
    expr_q.delete();
    case (kind)
      KIND_DEEP, KIND_OVERFLOW: begin
        // each step nets one stack entry: either '(' or operand then '^'
        // (right-assoc, so the '^' stays while the operand pops)
        n = (kind == KIND_OVERFLOW) ? 36 : $urandom_range(24, 40);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 1)) begin
            expr_q.push_back(CH_LPAREN);
          end else begin
            expr_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
            expr_q.push_back(CH_CARET);
          end
        end
        expr_q.push_back(8'($urandom_range(8'h30, 8'h39)));
        repeat ($urandom_range(0, 3)) expr_q.push_back(CH_RPAREN);
      end
      KIND_WELLFORMED: begin
        n = $urandom_range(1, 7);
        for (int t = 0; t < n; t++) begin
          while (open < 5 && $urandom_range(0, 3) == 0) begin
            expr_q.push_back(CH_LPAREN);
            open++;
          end
          if ($urandom_range(0, 3) == 0)
            expr_q.push_back(8'($urandom_range(8'h30, 8'h39)));
          else
            expr_q.push_back(8'($urandom_range(8'h61, 8'h7A)));
          while (open > 0 && $urandom_range(0, 2) == 0) begin
            expr_q.push_back(CH_RPAREN);
            open--;
          end
          if (t < n - 1)
            expr_q.push_back(SPECIALS[$urandom_range(3, 8)]);
        end
        while (open > 0) begin
          expr_q.push_back(CH_RPAREN);
          open--;
        end
      end
      default: begin
        // junk: full byte range mixed with stray parens, '#' and operators
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 1))
            expr_q.push_back(8'($urandom_range(0, 255)));
          else
            expr_q.push_back(SPECIALS[$urandom_range(0, 8)]);
        end
      end
    endcase
  endfunction

  initial begin : stimulus
    // directed: all operators with precedence and associativity, matched parens,
    // unmatched ')' pushed then popped by '#', '#' blocking pops of a later '+',
    // a lone '(' flushed out, and the byte extremes as operands
    string      directed [4] = '{"a+b*c-d/e", "(a^b)$c", ")#+b", "("};
    int         roll;
    int         phase_start;
    expr_kind_t kind;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct   = 13;
    recv_stall_pct = 48;
    foreach (directed[d]) begin
      expr_q.delete();
      for (int c = 0; c < directed[d].len(); c++)
        expr_q.push_back(directed[d][c]);
      send_expr();
    end
    expr_q = '{8'h00, 8'hFF};
    send_expr();
    drain();

    // phase 0: light sender gaps, heavy stall; phase 1 swapped; phase 2 full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_gap_pct = 13; recv_stall_pct = 48; end
        1:       begin send_gap_pct = 48; recv_stall_pct = 13; end
        default: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      phase_start = sent_items;
      if (phase == 0) begin
        // guaranteed overflow: sticky flag must show on the terminator only
        compose_expr(KIND_OVERFLOW);
        send_expr();
      end
      while (sent_items - phase_start < ITEMS_PER_PHASE) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          kind = KIND_DEEP;
        else if (roll < 80)
          kind = KIND_WELLFORMED;
        else
          kind = KIND_NOISE;
        compose_expr(kind);
        send_expr();
        if ($urandom_range(0, 9) == 0)
          drain();
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && backlog == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
